// ===== rtl/core/uph_pkg.sv =====
// ----------------------------------------------------------------------------
// uph_pkg
// Shared types, decode constants and hash helpers for the path hash block.
// ----------------------------------------------------------------------------
package uph_pkg;

    localparam logic [31:0] INVALID_CP = 32'hFFFF_FFFF;
    localparam logic [7:0]  LEAD2_LO   = 8'hC2;
    localparam logic [7:0]  LEAD2_HI   = 8'hDF;
    localparam logic [3:0]  LEAD3_TAG  = 4'hE;
    localparam logic [7:0]  LEAD4      = 8'hF0;
    localparam logic [1:0]  CONT_TAG   = 2'b10;
    localparam logic [7:0]  BACKSLASH  = 8'h5C;
    localparam logic [7:0]  SLASH      = 8'h2F;
    localparam logic [15:0] LEN_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [31:0] hash;
        logic [7:0]  lead;
        logic [1:0]  seen;
        logic [17:0] part;
        logic [15:0] count;
    } uph_state_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hash;
        logic [15:0] length;
    } uph_result_t;

    function automatic logic [31:0] mix(input logic [31:0] h, input logic [31:0] cp);
        logic [31:0] v;
        v = (cp == {24'd0, BACKSLASH}) ? {24'd0, SLASH} : cp;
        return {h[24:0], h[31:25]} + v;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] c, input logic [2:0] n);
        logic [16:0] s;
        s = {1'b0, c} + {14'd0, n};
        return s[16] ? LEN_MAX : s[15:0];
    endfunction

endpackage

// ===== rtl/core/uph_step.sv =====
// ----------------------------------------------------------------------------
// uph_step
// Per-byte decode and hash update: next string state and end-of-string result.
// ----------------------------------------------------------------------------
module uph_step (
    input  uph_pkg::uph_state_t  state_cur,
    input  logic [7:0]           in_byte,
    output uph_pkg::uph_state_t  state_nxt,
    output uph_pkg::uph_result_t result
);
    import uph_pkg::*;

    logic [1:0]  need;
    logic [1:0]  seen1;
    logic [17:0] part1;
    logic        fresh;

    always_comb begin
        state_nxt = state_cur;
        result    = '0;
        fresh     = 1'b1;
        if (state_cur.lead >= LEAD2_LO && state_cur.lead <= LEAD2_HI) begin
            need = 2'd1;
        end else if (state_cur.lead[7:4] == LEAD3_TAG) begin
            need = 2'd2;
        end else begin
            need = 2'd3;
        end
        seen1 = state_cur.seen + 2'd1;
        part1 = {state_cur.part[11:0], in_byte[5:0]};

        if (state_cur.lead != 8'd0) begin
            if (in_byte[7:6] == CONT_TAG) begin
                fresh          = 1'b0;
                state_nxt.seen = seen1;
                state_nxt.part = part1;
                if (seen1 >= need) begin
                    state_nxt.lead = 8'd0;
                    state_nxt.seen = 2'd0;
                    state_nxt.part = 18'd0;
                    if (part1 == 18'd0) begin
                        result.done   = 1'b1;
                        result.hash   = state_cur.hash;
                        result.length = state_cur.count;
                        state_nxt     = '0;
                    end else begin
                        state_nxt.hash  = mix(state_cur.hash, {14'd0, part1});
                        state_nxt.count = sat_add(state_cur.count, {1'b0, seen1} + 3'd1);
                    end
                end
            end else begin
                // broken sequence: one invalid codepoint per byte taken so far
                state_nxt.hash = mix(state_nxt.hash, INVALID_CP);
                if (state_cur.seen >= 2'd1) begin
                    state_nxt.hash = mix(state_nxt.hash, INVALID_CP);
                end
                if (state_cur.seen >= 2'd2) begin
                    state_nxt.hash = mix(state_nxt.hash, INVALID_CP);
                end
                state_nxt.count = sat_add(state_cur.count, {1'b0, state_cur.seen} + 3'd1);
                state_nxt.lead  = 8'd0;
                state_nxt.seen  = 2'd0;
                state_nxt.part  = 18'd0;
            end
        end

        if (fresh) begin
            if (in_byte == 8'd0) begin
                result.done   = 1'b1;
                result.hash   = state_nxt.hash;
                result.length = state_nxt.count;
                state_nxt     = '0;
            end else if (in_byte[7] == 1'b0) begin
                state_nxt.hash  = mix(state_nxt.hash, {24'd0, in_byte});
                state_nxt.count = sat_add(state_nxt.count, 3'd1);
            end else if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
                state_nxt.lead = in_byte;
                state_nxt.part = {13'd0, in_byte[4:0]};
            end else if (in_byte[7:4] == LEAD3_TAG) begin
                state_nxt.lead = in_byte;
                state_nxt.part = {14'd0, in_byte[3:0]};
            end else if (in_byte == LEAD4) begin
                state_nxt.lead = in_byte;
                state_nxt.part = 18'd0;
            end else begin
                state_nxt.hash  = mix(state_nxt.hash, INVALID_CP);
                state_nxt.count = sat_add(state_nxt.count, 3'd1);
            end
        end
    end

endmodule

// ===== rtl/core/utf8_path_rotate_add_hash.sv =====
// ----------------------------------------------------------------------------
// utf8_path_rotate_add_hash
// Streaming UTF-8 path hash: one byte per request in, one hash per string out.
// ----------------------------------------------------------------------------
// s_valid/s_ready/s_in_byte carry the path one byte per request; a zero byte
// (or an overlong form decoding to zero) ends the string.
// m_valid/m_ready/m_path_hash/m_byte_length carry one result per string.
// A byte waits in the input register while the step logic decodes it and
// folds it into the hash; a terminator's result is then loaded into the
// result register, which a stalled receiver can delay. Throughput is one
// byte per cycle while the receiver does not stall, set by the single pass
// through the step logic (up to four chained rotate-add updates).
// The receiver stalling holds the result; further bytes keep flowing until
// the next terminator reaches the input register, which then waits there.
// Reset clears the hash, the pending sequence, the byte count and both
// valid flags.
// ----------------------------------------------------------------------------
module utf8_path_rotate_add_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_path_hash,
    output logic [15:0] m_byte_length
);
    import uph_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    uph_state_t  state_reg;
    uph_state_t  state_next;
    uph_result_t step_result;
    logic        out_valid_reg;
    logic [31:0] out_hash_reg;
    logic [15:0] out_len_reg;
    logic        step_ok;
    logic        advance;

    uph_step u_step (
        .state_cur (state_reg),
        .in_byte   (in_byte_reg),
        .state_nxt (state_next),
        .result    (step_result)
    );

    assign step_ok = !step_result.done || !out_valid_reg || m_ready;
    assign advance = in_valid_reg && step_ok;
    assign s_ready = !in_valid_reg || step_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance && step_result.done) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
        if (advance && step_result.done) begin
            out_hash_reg <= step_result.hash;
            out_len_reg  <= step_result.length;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_path_hash   = out_hash_reg;
    assign m_byte_length = out_len_reg;

endmodule

// ===== rtl/core/uph_checker.sv =====
// ----------------------------------------------------------------------------
// uph_checker
// Port-level checks on the path hash block, bound to its top level.
// ----------------------------------------------------------------------------
module uph_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_path_hash,
    input logic [15:0] m_byte_length
);

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_path_hash) && $stable(m_byte_length))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // input stalls only behind a pending result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

endmodule

bind utf8_path_rotate_add_hash uph_checker u_uph_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_path_hash   (m_path_hash),
    .m_byte_length (m_byte_length)
);

// ===== verif/utf8_path_rotate_add_hash_checker.sv =====
// ----------------------------------------------------------------------------
// utf8_path_rotate_add_hash_checker
// Watches both channels of the path hash block and compares every result.
// Each accepted byte request runs through a local UTF-8 decode and
// rotate-add hash. Each string end queues the predicted hash and length.
// Each accepted result is compared field by field with the oldest
// queued entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_path_rotate_add_hash_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_path_hash,
    input  logic [15:0] m_byte_length,
    output int          fail_count,
    output int          waiting,
    output int          compared
);
    import uph_pkg::*;

    typedef struct packed {
        logic [31:0] hash;
        logic [15:0] length;
    } path_sum_t;

    path_sum_t   expected_sums[$];

    logic [31:0] acc_hash;
    logic [7:0]  lead_byte;
    logic [1:0]  cont_cnt;
    logic [17:0] cp_bits;
    logic [15:0] len_cnt;

    task automatic clear_path();
        acc_hash  = '0;
        lead_byte = '0;
        cont_cnt  = '0;
        cp_bits   = '0;
        len_cnt   = '0;
    endtask

    task automatic fold_cp(input logic [31:0] cp);
        logic [31:0] v;
        v = (cp == {24'd0, BACKSLASH}) ? {24'd0, SLASH} : cp;
        acc_hash = {acc_hash[24:0], acc_hash[31:25]} + v;
    endtask

    task automatic bump_len(input logic [2:0] n);
        logic [16:0] s;
        s = {1'b0, len_cnt} + {14'd0, n};
        len_cnt = s[16] ? LEN_MAX : s[15:0];
    endtask

    task automatic close_path();
        expected_sums.push_back({acc_hash, len_cnt});
        clear_path();
    endtask

    function automatic logic [1:0] conts_for(input logic [7:0] lead);
        if (lead >= LEAD2_LO && lead <= LEAD2_HI) return 2'd1;
        if (lead[7:4] == LEAD3_TAG) return 2'd2;
        return 2'd3;
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        logic [1:0]  need;
        logic [17:0] cp;
        logic [2:0]  n;
        int          i;
        if (lead_byte != 8'd0) begin
            if (b[7:6] == CONT_TAG) begin
                need     = conts_for(lead_byte);
                cont_cnt = cont_cnt + 2'd1;
                cp_bits  = {cp_bits[11:0], b[5:0]};
                if (cont_cnt >= need) begin
                    cp        = cp_bits;
                    n         = {1'b0, cont_cnt} + 3'd1;
                    lead_byte = '0;
                    cont_cnt  = '0;
                    cp_bits   = '0;
                    if (cp == 18'd0) begin
                        close_path();
                    end else begin
                        fold_cp({14'd0, cp});
                        bump_len(n);
                    end
                end
                return;
            end
            // broken sequence: lead and each taken continuation are invalid
            for (i = 0; i <= int'(cont_cnt); i++) fold_cp(INVALID_CP);
            bump_len({1'b0, cont_cnt} + 3'd1);
            lead_byte = '0;
            cont_cnt  = '0;
            cp_bits   = '0;
        end
        if (b == 8'd0) begin
            close_path();
        end else if (!b[7]) begin
            fold_cp({24'd0, b});
            bump_len(3'd1);
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            lead_byte = b;
            cp_bits   = {13'd0, b[4:0]};
        end else if (b[7:4] == LEAD3_TAG) begin
            lead_byte = b;
            cp_bits   = {14'd0, b[3:0]};
        end else if (b == LEAD4) begin
            lead_byte = b;
            cp_bits   = '0;
        end else begin
            fold_cp(INVALID_CP);
            bump_len(3'd1);
        end
    endtask

    always @(posedge aclk) begin
        path_sum_t want;
        path_sum_t got;
        if (!aresetn) begin
            clear_path();
            expected_sums.delete();
            fail_count = 0;
            compared   = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_path_hash, m_byte_length};
                if (expected_sums.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: hash %h length %0d", got.hash, got.length);
                end else begin
                    want = expected_sums.pop_front();
                    compared++;
                    if (got.hash !== want.hash || got.length !== want.length) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch on result %0d: hash %h/%h length %0d/%0d",
                                     compared, want.hash, got.hash, want.length, got.length);
                    end
                end
            end
            if (s_valid && s_ready) absorb_byte(s_in_byte);
        end
        waiting = expected_sums.size();
    end

endmodule

// ===== verif/utf8_path_rotate_add_hash_test.sv =====
// ----------------------------------------------------------------------------
// utf8_path_rotate_add_hash_test
// Stimulus and verdict for the UTF-8 path hash block.
// Drives a short directed set of strings, a burst against a long output
// stall, then random mostly well-formed paths with noise, under random
// idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_path_rotate_add_hash_test;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_BYTES = 1450;
    localparam int CHOKE_CYCLES = 300;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte  = 8'd0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic [31:0] m_path_hash;
    logic [15:0] m_byte_length;

    logic        s_took     = 1'b0;
    logic        bursty     = 1'b0;
    logic        choke_req  = 1'b0;
    logic        choke_done = 1'b0;
    int          cycles     = 0;
    int          bytes_sent = 0;
    int          fail_count;
    int          waiting;
    int          compared;
    logic [7:0]  seq[$];

    utf8_path_rotate_add_hash u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_path_hash   (m_path_hash),
        .m_byte_length (m_byte_length)
    );

    utf8_path_rotate_add_hash_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_path_hash   (m_path_hash),
        .m_byte_length (m_byte_length),
        .fail_count    (fail_count),
        .waiting       (waiting),
        .compared      (compared)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        s_took <= s_valid && s_ready;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, waiting);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (choke_req && !choke_done) begin
                m_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(negedge aclk);
                choke_done <= 1'b1;
                m_ready    <= 1'b1;
            end else if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if (!bursty && $urandom_range(0, 3) == 0) hold = idle_len();
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = bursty ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) begin
                s_in_byte <= 8'($urandom);
                @(negedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(negedge aclk); while (!s_took);
        bytes_sent++;
    endtask

    task automatic send_seq();
        int i;
        for (i = 0; i < seq.size(); i++) push_byte(seq[i]);
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic send_random_path();
        int len;
        int kind;
        int i;
        int k;
        int n;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 14);
        for (i = 0; i < len; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 38) begin
                push_byte(8'($urandom_range(1, 127)));
            end else if (kind < 46) begin
                push_byte(8'h5C);
            end else if (kind < 60) begin
                push_byte(8'($urandom_range('hC2, 'hDF)));
                push_byte(cont_byte());
            end else if (kind < 72) begin
                push_byte({4'hE, 4'($urandom)});
                push_byte(cont_byte());
                push_byte(cont_byte());
            end else if (kind < 82) begin
                push_byte(8'hF0);
                for (k = 0; k < 3; k++) push_byte(cont_byte());
            end else if (kind < 88) begin
                if ($urandom_range(0, 1) == 0)
                    push_byte(8'($urandom_range('h80, 'hC1)));
                else
                    push_byte(8'($urandom_range('hF1, 'hFF)));
            end else if (kind < 95) begin
                // truncated sequence, broken by whatever follows unless that is a continuation byte
                case ($urandom_range(0, 2))
                    0: begin
                        push_byte(8'($urandom_range('hC2, 'hDF)));
                        n = 0;
                    end
                    1: begin
                        push_byte({4'hE, 4'($urandom)});
                        n = $urandom_range(0, 1);
                    end
                    default: begin
                        push_byte(8'hF0);
                        n = $urandom_range(0, 2);
                    end
                endcase
                for (k = 0; k < n; k++) push_byte(cont_byte());
            end else if (kind < 98) begin
                push_byte(8'($urandom));
            end else begin
                // overlong null ends the string early
                if ($urandom_range(0, 1) == 0) push_byte(8'hE0);
                else begin
                    push_byte(8'hF0);
                    push_byte(8'h80);
                end
                push_byte(8'h80);
                push_byte(8'h80);
            end
        end
        push_byte(8'h00);
    endtask

    initial begin
        int i;
        int stop_at;
        logic [7:0] b;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed strings
        seq = '{8'h00};
        send_seq();
        seq = '{8'h61, 8'h5C, 8'h7F, 8'h01, 8'h00};
        send_seq();
        seq = '{8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h81, 8'hEF, 8'hBF, 8'hBF,
                8'hF0, 8'hBF, 8'hBF, 8'hBF, 8'h00};
        send_seq();
        seq = '{8'h80, 8'hC1, 8'hF1, 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'h5C,
                8'hF0, 8'h90, 8'h80, 8'hC3, 8'hA9, 8'h00};
        send_seq();
        seq = '{8'hE2, 8'h82, 8'h00};
        send_seq();
        seq = '{8'h41, 8'hF0, 8'h80, 8'h80, 8'h80, 8'hE0, 8'h80, 8'h80, 8'h00};
        send_seq();

        // short strings against a long result stall
        bursty    <= 1'b1;
        choke_req <= 1'b1;
        for (i = 0; i < 30; i++) begin
            b = 8'($urandom_range(1, 127));
            if ($urandom_range(0, 1) == 0) push_byte(b);
            push_byte(8'h00);
        end
        while (!choke_done) @(negedge aclk);
        bursty <= 1'b0;

        // random paths, with calm stretches now and then
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) bursty <= ~bursty;
            send_random_path();
        end

        s_valid <= 1'b0;
        while (waiting != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("drove %0d bytes, compared %0d path results", bytes_sent, compared);
        $display("included broken and overlong forms and a long stall on the result side");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d failures", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
